### rtl/ratio_and_cross_check_match_filter_macros.svh
// Assertion macros used by the filter top level.
`ifndef RATIO_AND_CROSS_CHECK_MATCH_FILTER_MACROS_SVH
`define RATIO_AND_CROSS_CHECK_MATCH_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// pre holds at an edge -> post holds at the same edge
`define RCMF_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("rcmf: same-cycle check failed");
// pre holds at an edge -> post holds at the next edge
`define RCMF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("rcmf: next-cycle check failed");
`else
`define RCMF_ASSERT_SAME(label, clk, rst_n, pre, post)
`define RCMF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

### rtl/rcmf_pkg.sv
package rcmf_pkg;

	localparam int IDX_W     = 9;
	localparam int RATIO_W   = 9;
	localparam int COUNT_W   = 10;
	localparam int STATUS_W  = 2;
	localparam int ACTION_W  = 2;
	localparam int EPOCH_W   = 4;

	localparam int DEF_MAX_KEYPOINTS = 512;
	localparam int DEF_DIST_BITS     = 9;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd205;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TEST  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RATIO_REJ  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_MUTUAL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_KEPT       = 2'd3;

	typedef enum logic {
		CTL_SWEEP,
		CTL_RUN
	} ctl_state_t;

	typedef struct packed {
		logic accept;    // request taken into stage 1
		logic commit;    // stage 1 result moves to the output register
		logic sweep_we;  // write an empty entry at the sweep address
	} cmd_t;

	typedef struct packed {
		logic need_sweep;  // stage 1 holds a clear that wraps the epoch
	} sts_t;

endpackage

### rtl/rcmf_ctrl.sv
module rcmf_ctrl import rcmf_pkg::*; #(
	parameter int MAX_KEYPOINTS = DEF_MAX_KEYPOINTS,
	localparam int ADDR_W = $clog2(MAX_KEYPOINTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  sts_t              sts,
	output cmd_t              cmd,
	output logic [ADDR_W-1:0] sweep_addr
);

	localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(MAX_KEYPOINTS - 1);

	ctl_state_t        state_q, state_d;
	logic              v_s1;
	logic              out_valid_q;
	logic [ADDR_W-1:0] sweep_cnt_q;
	logic              commit, accept, ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTL_SWEEP: begin
				if (sweep_cnt_q == SWEEP_LAST) begin
					state_d = CTL_RUN;
				end
			end
			CTL_RUN: begin
				if (commit && sts.need_sweep) begin
					state_d = CTL_SWEEP;
				end
			end
			default: state_d = CTL_SWEEP;
		endcase
	end

	always_comb begin
		commit = 1'b0;
		ready  = 1'b0;
		unique case (state_q)
			CTL_SWEEP: begin
				commit = 1'b0;
				ready  = 1'b0;
			end
			CTL_RUN: begin
				commit = v_s1 && (!out_valid_q || out_ready);
				// hold new requests while a wrapping clear waits in stage 1
				ready  = (!v_s1 || commit) && !(v_s1 && sts.need_sweep);
			end
			default: begin
				commit = 1'b0;
				ready  = 1'b0;
			end
		endcase
		accept = in_valid && ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_SWEEP;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			sweep_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (commit) begin
				v_s1 <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == CTL_SWEEP) begin
				sweep_cnt_q <= (sweep_cnt_q == SWEEP_LAST) ? '0 : sweep_cnt_q + 1'b1;
			end
		end
	end

	assign in_ready     = ready;
	assign out_valid    = out_valid_q;
	assign cmd.accept   = accept;
	assign cmd.commit   = commit;
	assign cmd.sweep_we = (state_q == CTL_SWEEP);
	assign sweep_addr   = sweep_cnt_q;

endmodule

### rtl/rcmf_datapath.sv
module rcmf_datapath import rcmf_pkg::*; #(
	parameter int MAX_KEYPOINTS = DEF_MAX_KEYPOINTS,
	parameter int DIST_BITS     = DEF_DIST_BITS,
	localparam int ADDR_W = $clog2(MAX_KEYPOINTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [ADDR_W-1:0]    sweep_addr,
	output sts_t                 sts,
	input  logic [RATIO_W-1:0]   ratio_q8,
	input  logic [ACTION_W-1:0]  action,
	input  logic [IDX_W-1:0]     query_index,
	input  logic [IDX_W-1:0]     train_index,
	input  logic [DIST_BITS-1:0] best_distance,
	input  logic [DIST_BITS-1:0] second_distance,
	output logic [STATUS_W-1:0]  status,
	output logic [IDX_W-1:0]     out_query_index,
	output logic [IDX_W-1:0]     out_train_index,
	output logic [DIST_BITS-1:0] out_distance,
	output logic [COUNT_W-1:0]   kept_count
);

	localparam int PROD_W = DIST_BITS + RATIO_W;
	localparam int WORD_W = EPOCH_W + IDX_W;

	// each entry: {epoch tag, target}; tag zero never matches a live epoch
	logic [WORD_W-1:0] mem [MAX_KEYPOINTS];

	logic [ACTION_W-1:0]  act_s1;
	logic [IDX_W-1:0]     q_s1, t_s1;
	logic [DIST_BITS-1:0] best_s1, second_s1;
	logic [WORD_W-1:0]    rd_word_q, fwd_word_q, look_word;
	logic                 fwd_hit_q;
	logic [EPOCH_W-1:0]   epoch_q;
	logic [COUNT_W-1:0]   count_q, count_d;

	logic [STATUS_W-1:0]  status_q, status_d;
	logic [IDX_W-1:0]     oq_q, ot_q;
	logic [DIST_BITS-1:0] od_q;
	logic [COUNT_W-1:0]   kept_q;

	logic [PROD_W-1:0]    lhs, rhs;
	logic                 pass, q_in_range, t_in_range, mutual;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr, rd_addr;
	logic [WORD_W-1:0]    wr_word;

	assign rd_addr = ADDR_W'(train_index);

	assign lhs  = PROD_W'({best_s1, 8'd0});
	assign rhs  = PROD_W'(ratio_q8) * PROD_W'(second_s1);
	assign pass = lhs < rhs;

	assign q_in_range = 32'(q_s1) < 32'(MAX_KEYPOINTS);
	assign t_in_range = 32'(t_s1) < 32'(MAX_KEYPOINTS);

	assign look_word = fwd_hit_q ? fwd_word_q : rd_word_q;
	assign mutual = t_in_range && (look_word[WORD_W-1:IDX_W] == epoch_q)
		&& (look_word[IDX_W-1:0] == q_s1);

	assign wr_en   = cmd.sweep_we || (cmd.commit && (act_s1 == ACT_LOAD) && pass && q_in_range);
	assign wr_addr = cmd.sweep_we ? sweep_addr : ADDR_W'(q_s1);
	assign wr_word = cmd.sweep_we ? '0 : {epoch_q, t_s1};

	assign sts.need_sweep = (act_s1 == ACT_CLEAR) && (epoch_q == EPOCH_LAST);

	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		unique case (act_s1)
			ACT_CLEAR: count_d = '0;
			ACT_TEST: begin
				if (!pass) begin
					status_d = ST_RATIO_REJ;
				end else if (mutual) begin
					status_d = ST_KEPT;
					if (count_q != COUNT_MAX) begin
						count_d = count_q + 1'b1;
					end
				end else begin
					status_d = ST_NOT_MUTUAL;
				end
			end
			default: begin
				status_d = ST_DONE;
				count_d  = count_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (cmd.accept) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_s1     <= action;
			q_s1       <= query_index;
			t_s1       <= train_index;
			best_s1    <= best_distance;
			second_s1  <= second_distance;
			// the memory returns old data when the same entry is written this edge
			fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
			fwd_word_q <= wr_word;
		end
		if (cmd.commit) begin
			status_q <= status_d;
			oq_q     <= (act_s1 == ACT_TEST) ? q_s1 : '0;
			ot_q     <= (act_s1 == ACT_TEST) ? t_s1 : '0;
			od_q     <= (act_s1 == ACT_TEST) ? best_s1 : '0;
			kept_q   <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= EPOCH_FIRST;
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			if (act_s1 == ACT_CLEAR) begin
				epoch_q <= sts.need_sweep ? EPOCH_FIRST : epoch_q + 1'b1;
			end
		end
	end

	assign status          = status_q;
	assign out_query_index = oq_q;
	assign out_train_index = ot_q;
	assign out_distance    = od_q;
	assign kept_count      = kept_q;

endmodule

### rtl/ratio_and_cross_check_match_filter.sv
// Channel   Handshake            Payload
// request   in_valid/in_ready    action, query_index, train_index, best/second_distance
// result    out_valid/out_ready  status, out_query_index, out_train_index,
//                                out_distance, kept_count
// config    APB (psel/penable)   ratio_q8 at byte address 0
//
// One request per cycle when results are taken; each request waits in stage 1
// behind a registered table read, then sits in the output register.
// After reset, the whole table is swept clear before in_ready rises.
// Clears bump an epoch tag; every 15th clear repeats that sweep.
// A stalled result holds stage 1, which holds in_ready low.
`include "ratio_and_cross_check_match_filter_macros.svh"

module ratio_and_cross_check_match_filter import rcmf_pkg::*; #(
	parameter int MAX_KEYPOINTS = DEF_MAX_KEYPOINTS,
	parameter int DIST_BITS     = DEF_DIST_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [ACTION_W-1:0]  action,
	input  logic [IDX_W-1:0]     query_index,
	input  logic [IDX_W-1:0]     train_index,
	input  logic [DIST_BITS-1:0] best_distance,
	input  logic [DIST_BITS-1:0] second_distance,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic [IDX_W-1:0]     out_query_index,
	output logic [IDX_W-1:0]     out_train_index,
	output logic [DIST_BITS-1:0] out_distance,
	output logic [COUNT_W-1:0]   kept_count
);

	localparam int ADDR_W = $clog2(MAX_KEYPOINTS);
	localparam logic REG_RATIO_Q8 = 1'b0;

	logic [RATIO_W-1:0] ratio_q8_q;
	cmd_t               cmd;
	sts_t               sts;
	logic [ADDR_W-1:0]  sweep_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q8_q <= RATIO_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RATIO_Q8)) begin
			ratio_q8_q <= pwdata[RATIO_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RATIO_Q8) ? 32'(ratio_q8_q) : '0;

	rcmf_ctrl #(
		.MAX_KEYPOINTS (MAX_KEYPOINTS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sts        (sts),
		.cmd        (cmd),
		.sweep_addr (sweep_addr)
	);

	rcmf_datapath #(
		.MAX_KEYPOINTS (MAX_KEYPOINTS),
		.DIST_BITS     (DIST_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sweep_addr      (sweep_addr),
		.sts             (sts),
		.ratio_q8        (ratio_q8_q),
		.action          (action),
		.query_index     (query_index),
		.train_index     (train_index),
		.best_distance   (best_distance),
		.second_distance (second_distance),
		.status          (status),
		.out_query_index (out_query_index),
		.out_train_index (out_train_index),
		.out_distance    (out_distance),
		.kept_count      (kept_count)
	);

	`RCMF_ASSERT_SAME(a_kept_counted, clk, arst_n, out_valid && (status == ST_KEPT), kept_count != '0)
	`RCMF_ASSERT_SAME(a_done_no_fields, clk, arst_n, out_valid && (status == ST_DONE), (out_query_index == '0) && (out_train_index == '0) && (out_distance == '0))
	`RCMF_ASSERT_SAME(a_sweep_blocks, clk, arst_n, cmd.sweep_we, !in_ready && !cmd.commit)
	`RCMF_ASSERT_NEXT(a_wrap_sweeps, clk, arst_n, cmd.commit && sts.need_sweep, cmd.sweep_we)

endmodule

### dv/tb_ratio_and_cross_check_match_filter.sv
module tb_ratio_and_cross_check_match_filter;
	import rcmf_pkg::*;

	localparam int DIST_W = DEF_DIST_BITS;
	localparam int KEYPOINTS = DEF_MAX_KEYPOINTS;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [2:0] RATIO_ADDR = 3'd0;
	localparam int PHASE_ITEMS = 35;
	localparam int SATURATION_ITEMS = 1100;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [IDX_W-1:0]    query_index;
		logic [IDX_W-1:0]    train_index;
		logic [DIST_W-1:0]   best_distance;
		logic [DIST_W-1:0]   second_distance;
	} match_request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    query_index;
		logic [IDX_W-1:0]    train_index;
		logic [DIST_W-1:0]   distance;
		logic [COUNT_W-1:0]  kept_count;
	} filter_result_t;

	class match_filter_mirror;
		logic [RATIO_W-1:0] ratio_q8;
		logic [IDX_W-1:0]   reverse_target[];
		bit                 reverse_valid[];
		logic [COUNT_W-1:0] kept_total;
		filter_result_t     expected_results[$];
		int mismatches;
		int results_checked;
		int kept_seen;
		int rejected_seen;
		int lonely_seen;
		int done_seen;
		bit saturated_seen;

		function new();
			ratio_q8 = RATIO_RESET;
			reverse_target = new[KEYPOINTS];
			reverse_valid = new[KEYPOINTS];
			foreach (reverse_valid[i]) reverse_valid[i] = 1'b0;
			kept_total = '0;
			mismatches = 0;
			results_checked = 0;
			kept_seen = 0;
			rejected_seen = 0;
			lonely_seen = 0;
			done_seen = 0;
			saturated_seen = 1'b0;
		endfunction

		function bit ratio_ok(input logic [DIST_W-1:0] best, input logic [DIST_W-1:0] second);
			int unsigned lhs;
			int unsigned rhs;
			lhs = int'(best) * 256;
			rhs = int'(ratio_q8) * int'(second);
			return lhs < rhs;
		endfunction

		function void flag(input string msg);
			mismatches++;
			if (mismatches <= 10) $display("%s", msg);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void note_request(input match_request_t req);
			filter_result_t want;
			want = '0;
			case (req.action)
				ACT_CLEAR: begin
					foreach (reverse_valid[i]) reverse_valid[i] = 1'b0;
					kept_total = '0;
				end
				ACT_LOAD: begin
					if (ratio_ok(req.best_distance, req.second_distance)) begin
						reverse_target[req.query_index] = req.train_index;
						reverse_valid[req.query_index] = 1'b1;
					end
				end
				ACT_TEST: begin
					want.query_index = req.query_index;
					want.train_index = req.train_index;
					want.distance = req.best_distance;
					if (!ratio_ok(req.best_distance, req.second_distance)) begin
						want.status = ST_RATIO_REJ;
					end else if (reverse_valid[req.train_index] &&
						reverse_target[req.train_index] == req.query_index) begin
						want.status = ST_KEPT;
						if (kept_total != COUNT_MAX) kept_total++;
					end else begin
						want.status = ST_NOT_MUTUAL;
					end
				end
				default: ;
			endcase
			want.kept_count = kept_total;
			expected_results = {expected_results, want};
		endfunction

		function void check_result(input filter_result_t got);
			filter_result_t want;
			if (expected_results.size() == 0) begin
				flag($sformatf("unexpected result: status %0d q %0d t %0d dist %0d count %0d",
					got.status, got.query_index, got.train_index, got.distance,
					got.kept_count));
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			if (got.status !== want.status || got.query_index !== want.query_index ||
				got.train_index !== want.train_index || got.distance !== want.distance ||
				got.kept_count !== want.kept_count) begin
				flag($sformatf({"result %0d mismatch: expected status %0d q %0d t %0d dist %0d ",
					"count %0d, got status %0d q %0d t %0d dist %0d count %0d"},
					results_checked, want.status, want.query_index, want.train_index,
					want.distance, want.kept_count, got.status, got.query_index,
					got.train_index, got.distance, got.kept_count));
			end
			case (want.status)
				ST_KEPT: kept_seen++;
				ST_RATIO_REJ: rejected_seen++;
				ST_NOT_MUTUAL: lonely_seen++;
				default: done_seen++;
			endcase
			if (want.kept_count == COUNT_MAX) saturated_seen = 1'b1;
		endfunction

		function void check_readback(input logic [RATIO_W-1:0] got);
			if (got !== ratio_q8)
				flag($sformatf("ratio_q8 readback: expected %0d, got %0d", ratio_q8, got));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic [ACTION_W-1:0]  action;
	logic [IDX_W-1:0]     query_index;
	logic [IDX_W-1:0]     train_index;
	logic [DIST_W-1:0]    best_distance;
	logic [DIST_W-1:0]    second_distance;
	logic                 out_valid;
	logic                 out_ready;
	logic [STATUS_W-1:0]  status;
	logic [IDX_W-1:0]     out_query_index;
	logic [IDX_W-1:0]     out_train_index;
	logic [DIST_W-1:0]    out_distance;
	logic [COUNT_W-1:0]   kept_count;

	match_filter_mirror mirror;
	logic [RATIO_W-1:0] ratio_now;
	bit no_idle;
	bit hold_results;
	int requests_sent;
	int ratio_settings;

	ratio_and_cross_check_match_filter dut (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int pick_gap();
		int roll;
		if (no_idle) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [IDX_W-1:0] rand_index();
		return IDX_W'($urandom);
	endfunction

	function automatic logic [DIST_W-1:0] rand_raw_distance();
		return DIST_W'($urandom);
	endfunction

	function automatic logic [DIST_W-1:0] rand_distance();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 9'd256;
			2: return '1;
			3: return DIST_W'($urandom_range(0, 511));
			default: return DIST_W'($urandom_range(1, 256));
		endcase
	endfunction

	// Aim at the ratio boundary under the current threshold, with some plain noise.
	function automatic logic [DIST_W-1:0] near_bound_best(input logic [DIST_W-1:0] second);
		int lim;
		lim = (int'(ratio_now) * int'(second)) / 256;
		if (lim > 511) lim = 511;
		if ($urandom_range(0, 3) == 0) return rand_distance();
		if ($urandom_range(0, 2) == 0) return DIST_W'(lim);
		return DIST_W'($urandom_range(0, lim));
	endfunction

	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [IDX_W-1:0] q,
		input logic [IDX_W-1:0] t, input logic [DIST_W-1:0] best,
		input logic [DIST_W-1:0] second);
		match_request_t req;
		int gap;
		req = {act, q, t, best, second};
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		action <= act;
		query_index <= q;
		train_index <= t;
		best_distance <= best;
		second_distance <= second;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		mirror.note_request(req);
		if (act != ACT_UNUSED) requests_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_ratio(input logic [RATIO_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= RATIO_ADDR;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		mirror.ratio_q8 = value;
		ratio_now = value;
		ratio_settings++;
		// read back
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		mirror.check_readback(prdata[RATIO_W-1:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// An optional clear, one load batch, then forward tests that mostly mirror it.
	task automatic run_round();
		logic [IDX_W-1:0] pair_q[$];
		logic [IDX_W-1:0] pair_t[$];
		logic [IDX_W-1:0] q;
		logic [IDX_W-1:0] t;
		logic [DIST_W-1:0] second;
		int k;
		int roll;
		if ($urandom_range(0, 2) == 0)
			send_request(ACT_CLEAR, rand_index(), rand_index(), rand_raw_distance(),
				rand_raw_distance());
		repeat ($urandom_range(1, 12)) begin
			q = rand_index();
			t = rand_index();
			pair_q = {pair_q, q};
			pair_t = {pair_t, t};
			second = rand_distance();
			send_request(ACT_LOAD, q, t, near_bound_best(second), second);
		end
		repeat ($urandom_range(1, 16)) begin
			roll = $urandom_range(0, 99);
			k = $urandom_range(0, pair_q.size() - 1);
			second = rand_distance();
			if (roll < 60)
				send_request(ACT_TEST, pair_t[k], pair_q[k], near_bound_best(second), second);
			else if (roll < 75)
				send_request(ACT_TEST, rand_index(), pair_q[k], near_bound_best(second), second);
			else if (roll < 90)
				send_request(ACT_TEST, rand_index(), rand_index(), near_bound_best(second),
					second);
			else if (roll < 95)
				send_request(ACT_UNUSED, rand_index(), rand_index(), rand_raw_distance(),
					rand_raw_distance());
			else
				send_request(ACT_LOAD, rand_index(), rand_index(), near_bound_best(second),
					second);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			mirror.check_result({status, out_query_index, out_train_index, out_distance,
				kept_count});
	end

	always begin : result_sink
		int gap;
		bit was_hold;
		@(negedge clk);
		was_hold = hold_results;
		gap = was_hold ? HOLD_CYCLES : pick_gap();
		if (gap > 0) begin
			out_ready <= 1'b0;
			repeat (gap) @(negedge clk);
			if (was_hold) hold_results = 1'b0;
		end
		out_ready <= 1'b1;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [RATIO_W-1:0] ratio_plan[7];
		logic [IDX_W-1:0] sat_q[8];
		logic [IDX_W-1:0] sat_t[8];
		logic [DIST_W-1:0] second;
		int phase_end;
		int k;
		int roll;

		mirror = new();
		ratio_now = RATIO_RESET;
		no_idle = 1'b0;
		hold_results = 1'b0;
		requests_sent = 0;
		ratio_settings = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = ACT_CLEAR;
		query_index = '0;
		train_index = '0;
		best_distance = '0;
		second_distance = '0;
		out_ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		send_request(ACT_CLEAR, '0, '0, '0, '0);

		// Directed cases at the reset threshold
		send_request(ACT_UNUSED, '1, '1, '1, '1);
		send_request(ACT_UNUSED, '0, '0, '0, '0);
		send_request(ACT_LOAD, 9'd0, 9'd511, 9'd0, 9'd1);
		send_request(ACT_LOAD, 9'd511, 9'd0, 9'd10, 9'd100);
		send_request(ACT_TEST, 9'd511, 9'd0, 9'd0, 9'd511);
		send_request(ACT_TEST, 9'd0, 9'd511, 9'd10, 9'd100);
		send_request(ACT_TEST, 9'd1, 9'd0, 9'd0, 9'd1);
		send_request(ACT_TEST, 9'd7, 9'd3, 9'd0, 9'd1);
		send_request(ACT_TEST, 9'd511, 9'd0, 9'd0, 9'd0);
		send_request(ACT_TEST, 9'd511, 9'd0, 9'd511, 9'd511);
		send_request(ACT_TEST, 9'd511, 9'd0, 9'd256, 9'd256);
		send_request(ACT_TEST, 9'd511, 9'd0, 9'd4, 9'd5);
		send_request(ACT_TEST, 9'd511, 9'd0, 9'd5, 9'd5);
		send_request(ACT_LOAD, 9'd2, 9'd9, 9'd200, 9'd200);
		send_request(ACT_TEST, 9'd9, 9'd2, 9'd0, 9'd1);
		send_request(ACT_LOAD, 9'd0, 9'd100, 9'd1, 9'd2);
		send_request(ACT_TEST, 9'd511, 9'd0, 9'd1, 9'd2);
		send_request(ACT_TEST, 9'd100, 9'd0, 9'd1, 9'd2);
		send_request(ACT_CLEAR, '1, '1, '1, '1);
		send_request(ACT_TEST, 9'd100, 9'd0, 9'd1, 9'd2);

		ratio_plan = '{9'd205, 9'd256, 9'd0, 9'd511, 9'd1, 9'd128, 9'd0};
		ratio_plan[6] = RATIO_W'($urandom_range(0, 511));
		for (int p = 0; p < 7; p++) begin
			if (p > 0) begin
				drain_results();
				write_ratio(ratio_plan[p]);
			end
			no_idle = (p == 4);
			// hold results off while requests keep coming, so the pipeline backs up
			if (p == 2) hold_results = 1'b1;
			phase_end = requests_sent + PHASE_ITEMS;
			while (requests_sent < phase_end) run_round();
		end
		no_idle = 1'b0;

		// Keep matching without a clear until the count pins at its ceiling.
		drain_results();
		write_ratio(9'd256);
		send_request(ACT_CLEAR, '0, '0, '0, '0);
		for (int i = 0; i < 8; i++) begin
			sat_q[i] = IDX_W'(i * 64 + int'($urandom_range(0, 63)));
			sat_t[i] = rand_index();
			send_request(ACT_LOAD, sat_q[i], sat_t[i], '0, DIST_W'($urandom_range(1, 511)));
		end
		repeat (SATURATION_ITEMS) begin
			roll = $urandom_range(0, 99);
			k = $urandom_range(0, 7);
			second = DIST_W'($urandom_range(1, 511));
			if (roll < 96)
				send_request(ACT_TEST, sat_t[k], sat_q[k],
					DIST_W'($urandom_range(0, int'(second) - 1)), second);
			else if (roll < 98)
				send_request(ACT_UNUSED, rand_index(), rand_index(), rand_raw_distance(),
					rand_raw_distance());
			else
				send_request(ACT_TEST, rand_index(), rand_index(), rand_distance(),
					rand_distance());
		end
		send_request(ACT_CLEAR, '0, '0, '0, '0);
		send_request(ACT_TEST, sat_t[0], sat_q[0], '0, 9'd1);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests over %0d written thresholds: %0d kept, %0d ratio rejects,",
			requests_sent, ratio_settings, mirror.kept_seen, mirror.rejected_seen);
		$display("%0d not mutual, %0d clear/load/ignored; kept count saturated: %0d; mismatches: %0d",
			mirror.lonely_seen, mirror.done_seen, mirror.saturated_seen, mirror.mismatches);
		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
